FILE: rtl/r2fft_pkg.sv
package r2fft_pkg;

	// Fixed field widths
	localparam int WORK_WIDTH      = 24;
	localparam int BIN_INDEX_WIDTH = 6;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 3;
	localparam int OUT_TDATA_WIDTH = ((2 * WORK_WIDTH + BIN_INDEX_WIDTH + 7) / 8) * 8;

	// Parameter defaults
	localparam int DEF_MAX_LOG2_POINTS = 6;
	localparam int DEF_SAMPLE_WIDTH    = 16;
	localparam int DEF_TWIDDLE_WIDTH   = 16;

	// Reset values of the configuration registers
	localparam logic [CFG_DATA_WIDTH-1:0] LOG2_SIZE_RESET = CFG_DATA_WIDTH'(6);

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_LOG2_SIZE    = 2'd0,
		CFG_INVERSE_MODE = 2'd1
	} cfg_index_t;

	// pi and 1.0 in unsigned Q30
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;

	// Reciprocals of the series denominators: floor(x / d) = (x * ceil(2^k / d)) >> k
	// holds exactly for x below 2^31 with k = 31 + ceil(log2 d)
	localparam longint unsigned RCP_2   = ((64'd1 << 32) + 64'd1) / 64'd2;
	localparam longint unsigned RCP_6   = ((64'd1 << 34) + 64'd5) / 64'd6;
	localparam longint unsigned RCP_12  = ((64'd1 << 35) + 64'd11) / 64'd12;
	localparam longint unsigned RCP_20  = ((64'd1 << 36) + 64'd19) / 64'd20;
	localparam longint unsigned RCP_30  = ((64'd1 << 36) + 64'd29) / 64'd30;
	localparam longint unsigned RCP_42  = ((64'd1 << 37) + 64'd41) / 64'd42;
	localparam longint unsigned RCP_56  = ((64'd1 << 37) + 64'd55) / 64'd56;
	localparam longint unsigned RCP_72  = ((64'd1 << 38) + 64'd71) / 64'd72;
	localparam longint unsigned RCP_90  = ((64'd1 << 38) + 64'd89) / 64'd90;
	localparam longint unsigned RCP_110 = ((64'd1 << 38) + 64'd109) / 64'd110;
	localparam longint unsigned RCP_132 = ((64'd1 << 39) + 64'd131) / 64'd132;
	localparam longint unsigned RCP_156 = ((64'd1 << 39) + 64'd155) / 64'd156;

	// Cosine term n: reciprocal of (2n-1)(2n)
	function automatic longint unsigned cos_rcp(input int n);
		case (n)
			1:       return RCP_2;
			2:       return RCP_12;
			3:       return RCP_30;
			4:       return RCP_56;
			5:       return RCP_90;
			default: return RCP_132;
		endcase
	endfunction

	function automatic int cos_shift(input int n);
		case (n)
			1:       return 32;
			2:       return 35;
			3:       return 36;
			4:       return 37;
			5:       return 38;
			default: return 39;
		endcase
	endfunction

	// Sine term n: reciprocal of (2n)(2n+1)
	function automatic longint unsigned sin_rcp(input int n);
		case (n)
			1:       return RCP_6;
			2:       return RCP_20;
			3:       return RCP_42;
			4:       return RCP_72;
			5:       return RCP_110;
			default: return RCP_156;
		endcase
	endfunction

	function automatic int sin_shift(input int n);
		case (n)
			1:       return 34;
			2:       return 36;
			3:       return 37;
			4:       return 38;
			5:       return 38;
			default: return 39;
		endcase
	endfunction

	// cos or sin of r*pi/32, r in 0..8, unsigned Q30, seven-term series
	function automatic longint unsigned octant_q30(input int unsigned r, input bit sin_sel);
		longint unsigned th;
		longint unsigned t2;
		longint unsigned term;
		longint          acc;
		th = (PI_Q30 * longint'(r)) >> 5;
		t2 = (th * th) >> 30;
		if (sin_sel) begin
			term = th;
			acc  = longint'(th);
			for (int n = 1; n <= 6; n++) begin
				term = (((term * t2) >> 30) * sin_rcp(n)) >> sin_shift(n);
				if (n[0]) acc = acc - longint'(term);
				else      acc = acc + longint'(term);
			end
		end else begin
			term = ONE_Q30;
			acc  = longint'(ONE_Q30);
			for (int n = 1; n <= 6; n++) begin
				term = (((term * t2) >> 30) * cos_rcp(n)) >> cos_shift(n);
				if (n[0]) acc = acc - longint'(term);
				else      acc = acc + longint'(term);
			end
		end
		return (acc < 0) ? 64'd0 : longint'(acc);
	endfunction

	// Q30 to Q1.(tw-1), round half up, saturate
	function automatic longint to_twiddle(input longint unsigned v, input int tw);
		int              sh;
		longint unsigned rv;
		longint unsigned mx;
		sh = 31 - tw;
		rv = (v + (64'd1 << (sh - 1))) >> sh;
		mx = (64'd1 << (tw - 1)) - 64'd1;
		return longint'((rv > mx) ? mx : rv);
	endfunction

	// Twiddle table entry t: cos (sin_sel=0) or sin (sin_sel=1) of 2*pi*t/2^maxl
	function automatic longint tw_val(input int unsigned t, input int maxl, input int tw,
		input bit sin_sel);
		int unsigned q;
		q = t << (6 - maxl);
		if (q <= 8) begin
			return sin_sel ? to_twiddle(octant_q30(q, 1'b1), tw)
			               : to_twiddle(octant_q30(q, 1'b0), tw);
		end else if (q <= 16) begin
			return sin_sel ? to_twiddle(octant_q30(16 - q, 1'b0), tw)
			               : to_twiddle(octant_q30(16 - q, 1'b1), tw);
		end else if (q <= 24) begin
			return sin_sel ? to_twiddle(octant_q30(q - 16, 1'b0), tw)
			               : -to_twiddle(octant_q30(q - 16, 1'b1), tw);
		end
		return sin_sel ? to_twiddle(octant_q30(32 - q, 1'b1), tw)
		               : -to_twiddle(octant_q30(32 - q, 1'b0), tw);
	endfunction

endpackage

FILE: rtl/radix2_fft_ifft_core.sv
// Radix-2 decimation-in-time FFT / IFFT core, 2 to 2^MAX_LOG2_POINTS points.
// Samples enter on the s_* stream, one complex value per transaction, in
// natural order; bins leave on the m_* stream in natural order with m_tlast
// on the final bin. The cfg_* channel writes log2_size (index 0) and
// inverse_mode (index 1); either write drops a partly loaded frame. Write
// configuration only while no frame is in flight.
// Loading accepts one sample per cycle while s_tvalid is high (s_tready is
// high while loading). Samples are stored at bit-reversed addresses, so the
// butterfly passes start at once. One shared complex multiplier and adder
// runs (N/2)*log2 N butterflies, each through read, multiply, write a and
// write b (the work store has a single write port). Each bin is then read
// (S_ORD), registered (S_OFILL) and held until m_tready accepts it; the
// first bin follows the last butterfly through S_ORD and S_OFILL.
// The block takes no new sample until the last bin has been accepted.
// A stalled receiver holds the current bin in the output register.
// Reset: log2_size 6, forward mode, empty frame, no output pending.
module radix2_fft_ifft_core import r2fft_pkg::*; #(
	parameter int MAX_LOG2_POINTS = DEF_MAX_LOG2_POINTS,
	parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH,
	parameter int TWIDDLE_WIDTH   = DEF_TWIDDLE_WIDTH
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// sample_real, sample_imag
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// bin_real, bin_imag, bin_index
	output logic [OUT_TDATA_WIDTH-1:0]                m_tdata,
	output logic                                      m_tlast,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]                cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]                 cfg_data
);

	localparam int ADDR_W = MAX_LOG2_POINTS;
	localparam int DEPTH  = 1 << MAX_LOG2_POINTS;
	localparam int LW     = $clog2(MAX_LOG2_POINTS + 1);
	localparam int ST_W   = (MAX_LOG2_POINTS > 1) ? $clog2(MAX_LOG2_POINTS) : 1;
	localparam int TIDX_W = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1;
	localparam int OW     = WORK_WIDTH + 2;

	typedef enum logic [2:0] {
		S_LOAD, S_RD, S_MUL, S_WA, S_WB, S_ORD, S_OFILL, S_OWAIT
	} state_t;

	state_t                         state_q;
	logic [ADDR_W-1:0]              load_cnt_q, bf_q, out_idx_q;
	logic [ST_W-1:0]                stage_q;
	logic [CFG_DATA_WIDTH-1:0]      log2_size_q;
	logic                           inverse_q;
	logic                           out_valid_q, out_last_q;
	logic [WORK_WIDTH-1:0]          out_real_q, out_imag_q;
	logic [ADDR_W-1:0]              out_bin_q;
	logic signed [TWIDDLE_WIDTH-1:0] tw_real_q, tw_imag_q;

	// Work store and its registered read ports
	logic signed [WORK_WIDTH-1:0]   work_real [DEPTH];
	logic signed [WORK_WIDTH-1:0]   work_imag [DEPTH];
	logic signed [WORK_WIDTH-1:0]   rd_a_real_q, rd_a_imag_q, rd_b_real_q, rd_b_imag_q;

	logic [LW-1:0]                  l_eff;
	logic [ADDR_W-1:0]              n_last, half_last, m_mask, a_addr, b_addr, rd_addr;
	logic [ADDR_W-1:0]              rev_full, rev_addr, t_full;
	logic [ST_W-1:0]                tw_shift;
	logic [TIDX_W-1:0]              tw_idx;
	logic signed [TWIDDLE_WIDTH-1:0] rom_real, rom_imag;
	logic signed [WORK_WIDTH-1:0]   sum_real, sum_imag, dif_real, dif_imag;
	logic signed [WORK_WIDTH-1:0]   in_real, in_imag;
	logic                           s_accept, rd_en, we;
	logic [ADDR_W-1:0]              wr_addr;
	logic signed [WORK_WIDTH-1:0]   wr_real, wr_imag;
	logic signed [OW-1:0]           bias, res_real_x, res_imag_x;
	logic [WORK_WIDTH-1:0]          res_real, res_imag;

	// Effective size: 0 acts as 1, above the maximum acts as the maximum
	always_comb begin
		if (log2_size_q == '0)
			l_eff = LW'(1);
		else if (32'(log2_size_q) > MAX_LOG2_POINTS)
			l_eff = LW'(MAX_LOG2_POINTS);
		else
			l_eff = LW'(log2_size_q);
		n_last    = ADDR_W'((32'd1 << l_eff) - 32'd1);
		half_last = ADDR_W'((32'd1 << (l_eff - LW'(1))) - 32'd1);
	end

	// Butterfly addressing: insert a zero at bit 'stage' of the counter
	always_comb begin
		m_mask   = (ADDR_W'(1) << stage_q) - ADDR_W'(1);
		a_addr   = (((bf_q >> stage_q) << stage_q) << 1) | (bf_q & m_mask);
		b_addr   = a_addr | (ADDR_W'(1) << stage_q);
		tw_shift = ST_W'(MAX_LOG2_POINTS - 1) - stage_q;
		t_full   = (bf_q & m_mask) << tw_shift;
		tw_idx   = t_full[TIDX_W-1:0];
	end

	// Load address: bit-reversed within the active size
	always_comb begin
		for (int i = 0; i < ADDR_W; i++)
			rev_full[ADDR_W-1-i] = load_cnt_q[i];
		rev_addr = rev_full >> (LW'(ADDR_W) - l_eff);
	end

	// Input sample, conjugated in inverse mode
	always_comb begin
		in_real = WORK_WIDTH'($signed(s_tdata[SAMPLE_WIDTH-1:0]));
		in_imag = WORK_WIDTH'($signed(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
		if (inverse_q)
			in_imag = -in_imag;
	end

	r2fft_twiddle_rom #(
		.MAX_LOG2_POINTS (MAX_LOG2_POINTS),
		.TWIDDLE_WIDTH   (TWIDDLE_WIDTH)
	) u_rom (
		.index   (tw_idx),
		.tw_real (rom_real),
		.tw_imag (rom_imag)
	);

	r2fft_bfly #(
		.TWIDDLE_WIDTH (TWIDDLE_WIDTH)
	) u_bfly (
		.clk      (clk),
		.mul_en   (state_q == S_MUL),
		.a_real   (rd_a_real_q),
		.a_imag   (rd_a_imag_q),
		.b_real   (rd_b_real_q),
		.b_imag   (rd_b_imag_q),
		.w_real   (tw_real_q),
		.w_imag   (tw_imag_q),
		.sum_real (sum_real),
		.sum_imag (sum_imag),
		.dif_real (dif_real),
		.dif_imag (dif_imag)
	);

	// Store write and read port selection
	always_comb begin
		s_accept = (state_q == S_LOAD) && s_tvalid;
		rd_en    = (state_q == S_RD) || (state_q == S_ORD);
		rd_addr  = (state_q == S_ORD) ? out_idx_q : a_addr;
		we       = 1'b0;
		wr_addr  = a_addr;
		wr_real  = sum_real;
		wr_imag  = sum_imag;
		case (state_q)
			S_LOAD: begin
				we      = s_accept;
				wr_addr = rev_addr;
				wr_real = in_real;
				wr_imag = in_imag;
			end
			S_WA: we = 1'b1;
			S_WB: begin
				we      = 1'b1;
				wr_addr = b_addr;
				wr_real = dif_real;
				wr_imag = dif_imag;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			work_real[wr_addr] <= wr_real;
			work_imag[wr_addr] <= wr_imag;
		end
		if (rd_en) begin
			rd_a_real_q <= work_real[rd_addr];
			rd_a_imag_q <= work_imag[rd_addr];
			rd_b_real_q <= work_real[b_addr];
			rd_b_imag_q <= work_imag[b_addr];
		end
	end

	// Output value: inverse mode conjugates and divides by N with rounding
	always_comb begin
		bias       = OW'(1) <<< (l_eff - LW'(1));
		res_real_x = (OW'(rd_a_real_q) + bias) >>> l_eff;
		res_imag_x = (-OW'(rd_a_imag_q) + bias) >>> l_eff;
		res_real   = inverse_q ? res_real_x[WORK_WIDTH-1:0] : rd_a_real_q;
		res_imag   = inverse_q ? res_imag_x[WORK_WIDTH-1:0] : rd_a_imag_q;
	end

	// Sequencer: load, butterfly passes, unload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_cnt_q  <= '0;
			bf_q        <= '0;
			stage_q     <= '0;
			out_idx_q   <= '0;
			log2_size_q <= LOG2_SIZE_RESET;
			inverse_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (s_accept) begin
						if (load_cnt_q == n_last) begin
							load_cnt_q <= '0;
							bf_q       <= '0;
							stage_q    <= '0;
							state_q    <= S_RD;
						end else begin
							load_cnt_q <= load_cnt_q + ADDR_W'(1);
						end
					end
				end
				S_RD: begin
					tw_real_q <= rom_real;
					tw_imag_q <= rom_imag;
					state_q   <= S_MUL;
				end
				S_MUL: state_q <= S_WA;
				S_WA:  state_q <= S_WB;
				S_WB: begin
					if (bf_q == half_last) begin
						bf_q <= '0;
						if (32'(stage_q) == 32'(l_eff) - 32'd1) begin
							out_idx_q <= '0;
							state_q   <= S_ORD;
						end else begin
							stage_q <= stage_q + ST_W'(1);
							state_q <= S_RD;
						end
					end else begin
						bf_q    <= bf_q + ADDR_W'(1);
						state_q <= S_RD;
					end
				end
				S_ORD: state_q <= S_OFILL;
				S_OFILL: begin
					out_real_q  <= res_real;
					out_imag_q  <= res_imag;
					out_bin_q   <= out_idx_q;
					out_last_q  <= (out_idx_q == n_last);
					out_valid_q <= 1'b1;
					state_q     <= S_OWAIT;
				end
				S_OWAIT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_idx_q == n_last) begin
							state_q <= S_LOAD;
						end else begin
							out_idx_q <= out_idx_q + ADDR_W'(1);
							state_q   <= S_ORD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase

			// Register writes; either one drops a partial frame
			if (cfg_valid) begin
				case (cfg_index)
					CFG_LOG2_SIZE: begin
						log2_size_q <= cfg_data;
						load_cnt_q  <= '0;
					end
					CFG_INVERSE_MODE: begin
						inverse_q  <= cfg_data[0];
						load_cnt_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign s_tready  = (state_q == S_LOAD);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tlast   = out_last_q;
	assign m_tdata   = OUT_TDATA_WIDTH'({BIN_INDEX_WIDTH'(out_bin_q), out_imag_q, out_real_q});

endmodule

FILE: rtl/r2fft_twiddle_rom.sv
module r2fft_twiddle_rom import r2fft_pkg::*; #(
	parameter int MAX_LOG2_POINTS = DEF_MAX_LOG2_POINTS,
	parameter int TWIDDLE_WIDTH   = DEF_TWIDDLE_WIDTH,
	localparam int TIDX_W = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1
) (
	input  logic [TIDX_W-1:0]               index,
	output logic signed [TWIDDLE_WIDTH-1:0] tw_real,
	output logic signed [TWIDDLE_WIDTH-1:0] tw_imag
);

	localparam int HALF = 1 << (MAX_LOG2_POINTS - 1);

	logic signed [TWIDDLE_WIDTH-1:0] cos_tab [HALF];
	logic signed [TWIDDLE_WIDTH-1:0] sin_tab [HALF];

	// Constant table, folded from one octant of the series
	for (genvar g = 0; g < HALF; g++) begin : g_tab
		localparam logic signed [TWIDDLE_WIDTH-1:0] COS_V =
			TWIDDLE_WIDTH'(tw_val(g, MAX_LOG2_POINTS, TWIDDLE_WIDTH, 1'b0));
		localparam logic signed [TWIDDLE_WIDTH-1:0] SIN_V =
			TWIDDLE_WIDTH'(tw_val(g, MAX_LOG2_POINTS, TWIDDLE_WIDTH, 1'b1));
		assign cos_tab[g] = COS_V;
		assign sin_tab[g] = SIN_V;
	end

	// W = cos - j*sin
	assign tw_real = cos_tab[index];
	assign tw_imag = -sin_tab[index];

endmodule

FILE: rtl/r2fft_bfly.sv
module r2fft_bfly import r2fft_pkg::*; #(
	parameter int TWIDDLE_WIDTH = DEF_TWIDDLE_WIDTH
) (
	input  logic                            clk,
	input  logic                            mul_en,
	input  logic signed [WORK_WIDTH-1:0]    a_real,
	input  logic signed [WORK_WIDTH-1:0]    a_imag,
	input  logic signed [WORK_WIDTH-1:0]    b_real,
	input  logic signed [WORK_WIDTH-1:0]    b_imag,
	input  logic signed [TWIDDLE_WIDTH-1:0] w_real,
	input  logic signed [TWIDDLE_WIDTH-1:0] w_imag,
	output logic signed [WORK_WIDTH-1:0]    sum_real,
	output logic signed [WORK_WIDTH-1:0]    sum_imag,
	output logic signed [WORK_WIDTH-1:0]    dif_real,
	output logic signed [WORK_WIDTH-1:0]    dif_imag
);

	localparam int PW = WORK_WIDTH + TWIDDLE_WIDTH;
	localparam int XW = WORK_WIDTH + 2;
	localparam logic signed [PW:0] RND = (PW + 1)'(1) <<< (TWIDDLE_WIDTH - 2);

	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [PW:0]   x_real_full, x_imag_full;
	logic signed [XW-1:0] x_real, x_imag;
	logic signed [XW-1:0] a_real_x, a_imag_x;
	logic signed [XW-1:0] s_r, s_i, d_r, d_i;

	// Partial products of b*W
	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_rr_s1 <= PW'(b_real) * PW'(w_real);
			p_ii_s1 <= PW'(b_imag) * PW'(w_imag);
			p_ri_s1 <= PW'(b_real) * PW'(w_imag);
			p_ir_s1 <= PW'(b_imag) * PW'(w_real);
		end
	end

	// Combine, round half up to an integer, then add and subtract
	always_comb begin
		x_real_full = (PW + 1)'(p_rr_s1) - (PW + 1)'(p_ii_s1) + RND;
		x_imag_full = (PW + 1)'(p_ri_s1) + (PW + 1)'(p_ir_s1) + RND;
		x_real      = XW'(x_real_full >>> (TWIDDLE_WIDTH - 1));
		x_imag      = XW'(x_imag_full >>> (TWIDDLE_WIDTH - 1));
		a_real_x    = XW'(a_real);
		a_imag_x    = XW'(a_imag);
		s_r         = a_real_x + x_real;
		s_i         = a_imag_x + x_imag;
		d_r         = a_real_x - x_real;
		d_i         = a_imag_x - x_imag;
	end

	assign sum_real = s_r[WORK_WIDTH-1:0];
	assign sum_imag = s_i[WORK_WIDTH-1:0];
	assign dif_real = d_r[WORK_WIDTH-1:0];
	assign dif_imag = d_i[WORK_WIDTH-1:0];

endmodule
